// ===== hw/rtl/aocc_pkg.sv =====
package aocc_pkg;

  localparam int NUM_CHANNELS_DEF = 16;
  localparam int SAMPLE_BITS      = 12;

  localparam int CH_W      = 4;
  localparam int SMP_W     = 12;
  localparam int CORR_W    = 13;
  localparam int ACC_W     = 24;
  localparam int OFS_W     = 12;
  localparam int CNT_W     = 13;
  localparam int SHIFT_W   = 4;
  localparam int MASK_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  localparam logic [SMP_W-1:0] SAMPLE_MASK   = SMP_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [OFS_W-1:0] OFFSET_MAX    = '1;
  localparam logic [ACC_W-1:0] ACC_MAX       = '1;
  localparam logic [CNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [OFS_W-1:0] OFFSET_RESET  = OFS_W'(2048);

  localparam logic [MASK_W-1:0]  CAL_MASK_RESET   = MASK_W'(4095);
  localparam logic [MASK_W-1:0]  RAW_MASK_RESET   = '0;
  localparam logic [CNT_W-1:0]   CAL_FRAMES_RESET = CNT_W'(1024);
  localparam logic [SHIFT_W-1:0] CAL_SHIFT_RESET  = SHIFT_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_MASK       = 3'd0,
    CFG_RAW_MASK       = 3'd1,
    CFG_CAL_FRAMES     = 3'd2,
    CFG_CAL_SHIFT      = 3'd3,
    CFG_DEFAULT_OFFSET = 3'd4
  } cfg_idx_t;

endpackage

// ===== hw/rtl/adc_offset_calibrate_and_correct.sv =====
// ADC zero-offset calibration and correction.
// Input stream: one request per channel conversion pair. in_tdata holds channel,
// sample_first and sample_second; in_tlast marks the last channel of a frame.
// Output stream: one result per request, in order. out_tdata holds the channel
// and the signed corrected value; out_tuser holds valid_res and calibrated.
// After reset the block calibrates: calibrated channels accumulate their first
// sample and frame ends are counted. When the count reaches cal_frames the
// offsets are loaded and calibration ends; results before that, and those for
// channels >= NUM_CHANNELS, carry valid_res 0. Otherwise each result is the mean
// of both samples minus the channel offset, or the first sample for raw channels.
// A request taken passes the input register, then the result register, which
// presents it. Throughput: one request per cycle while the receiver accepts
// results; all state updates for a request complete in the cycle it moves into
// the result register, so back-to-back requests on one channel need no stall.
// When the receiver stalls, the result register holds and the input register
// fills; in_tready drops only when both are occupied.
// Reset (synchronous, active low) restores the configuration and valid flags,
// clears accumulators, loads offsets with 2048 and restarts calibration; the data
// registers are not reset. Write configuration only while no request is in flight.
module adc_offset_calibrate_and_correct import aocc_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [3:0] channel, [15:4] sample_first, [27:16] sample_second, [31:28] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [3:0] out_channel, [16:4] corrected, [23:17] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] valid_res, [1] calibrated
  output logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [MASK_W-1:0]  cal_mask_r;
  logic [MASK_W-1:0]  raw_mask_r;
  logic [CNT_W-1:0]   cal_frames_r;
  logic [SHIFT_W-1:0] cal_shift_r;
  logic [OFS_W-1:0]   default_offset_r;

  logic               s1_valid_r;
  logic [CH_W-1:0]    s1_ch_r;
  logic [SMP_W-1:0]   s1_s0_r;
  logic [SMP_W-1:0]   s1_s1_r;
  logic               s1_fend_r;

  logic               out_valid_r;
  logic [CH_W-1:0]    out_channel_r;
  logic [CORR_W-1:0]  corrected_r;
  logic               valid_res_r;
  logic               calibrated_r;

  logic [ACC_W-1:0]   acc_r   [NUM_CHANNELS];
  logic [ACC_W-1:0]   acc_nxt [NUM_CHANNELS];
  logic [OFS_W-1:0]   ofs_r   [NUM_CHANNELS];
  logic [OFS_W-1:0]   ofs_nxt [NUM_CHANNELS];
  logic [CNT_W-1:0]   fc_r;
  logic [CNT_W-1:0]   fc_nxt;
  logic               cal_done_r;
  logic               cal_done_nxt;

  logic               adv;
  logic               in_range;
  logic [SMP_W-1:0]   s0m;
  logic [SMP_W-1:0]   s1m;
  logic [CNT_W-1:0]   fc_inc;
  logic               finish;
  logic [OFS_W-1:0]   ofs_sel;
  logic [CORR_W-1:0]  mean;
  logic [CORR_W-1:0]  corrected_nxt;
  logic               valid_res_nxt;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_shr;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - CORR_W - CH_W)'(0), corrected_r, out_channel_r};
  assign out_tuser  = {calibrated_r, valid_res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_mask_r       <= CAL_MASK_RESET;
      raw_mask_r       <= RAW_MASK_RESET;
      cal_frames_r     <= CAL_FRAMES_RESET;
      cal_shift_r      <= CAL_SHIFT_RESET;
      default_offset_r <= OFFSET_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_CAL_MASK:       cal_mask_r       <= cfg_wdata;
        CFG_RAW_MASK:       raw_mask_r       <= cfg_wdata;
        CFG_CAL_FRAMES:     cal_frames_r     <= cfg_wdata[CNT_W-1:0];
        CFG_CAL_SHIFT:      cal_shift_r      <= cfg_wdata[SHIFT_W-1:0];
        CFG_DEFAULT_OFFSET: default_offset_r <= cfg_wdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_range = 32'(s1_ch_r) < NUM_CHANNELS;
    s0m      = s1_s0_r & SAMPLE_MASK;
    s1m      = s1_s1_r & SAMPLE_MASK;
    fc_inc   = (fc_r < COUNT_MAX) ? fc_r + CNT_W'(1) : fc_r;
    finish   = !cal_done_r && s1_fend_r && (fc_inc >= cal_frames_r);

    fc_nxt       = fc_r;
    cal_done_nxt = cal_done_r;
    if (adv && !cal_done_r && s1_fend_r) begin
      fc_nxt = finish ? '0 : fc_inc;
      if (finish) begin
        cal_done_nxt = 1'b1;
      end
    end

    for (int c = 0; c < NUM_CHANNELS; c++) begin
      acc_nxt[c] = acc_r[c];
      acc_sum    = {1'b0, acc_r[c]} + (ACC_W + 1)'(s0m);
      if (adv && !cal_done_r && cal_mask_r[c] && (s1_ch_r == CH_W'(c))) begin
        acc_nxt[c] = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
      end
      ofs_nxt[c] = ofs_r[c];
      acc_shr    = acc_nxt[c] >> cal_shift_r;
      if (adv && finish) begin
        if (cal_mask_r[c]) begin
          ofs_nxt[c] = (|acc_shr[ACC_W-1:OFS_W]) ? OFFSET_MAX : acc_shr[OFS_W-1:0];
        end else begin
          ofs_nxt[c] = default_offset_r;
        end
      end
    end

    ofs_sel = in_range ? ofs_r[s1_ch_r[IDX_W-1:0]] : '0;
    mean    = CORR_W'(({1'b0, s0m} + {1'b0, s1m}) >> 1);
    valid_res_nxt = cal_done_r && in_range;
    if (!valid_res_nxt) begin
      corrected_nxt = '0;
    end else if (raw_mask_r[s1_ch_r]) begin
      corrected_nxt = CORR_W'(s0m);
    end else begin
      corrected_nxt = mean - CORR_W'(ofs_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        acc_r[c] <= '0;
        ofs_r[c] <= OFFSET_RESET;
      end
      fc_r       <= '0;
      cal_done_r <= 1'b0;
    end else begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        acc_r[c] <= acc_nxt[c];
        ofs_r[c] <= ofs_nxt[c];
      end
      fc_r       <= fc_nxt;
      cal_done_r <= cal_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ch_r   <= in_tdata[CH_W-1:0];
      s1_s0_r   <= in_tdata[CH_W+SMP_W-1:CH_W];
      s1_s1_r   <= in_tdata[CH_W+2*SMP_W-1:CH_W+SMP_W];
      s1_fend_r <= in_tlast;
    end
    if (adv) begin
      out_channel_r <= s1_ch_r;
      corrected_r   <= corrected_nxt;
      valid_res_r   <= valid_res_nxt;
      calibrated_r  <= cal_done_nxt;
    end
  end

endmodule

// ===== hw/rtl/aocc_checker.sv =====
module aocc_checker import aocc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  logic seen_cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_cal_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tuser[1]) begin
      seen_cal_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_valid_needs_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[1])
    else $error("valid result before calibration finished");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[CH_W+CORR_W-1:CH_W] == '0)
    else $error("invalid result carries a nonzero value");

  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && seen_cal_r |-> out_tuser[1])
    else $error("calibrated flag dropped after calibration");

endmodule

bind adc_offset_calibrate_and_correct aocc_checker u_aocc_checker (.*);
